// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Fixed field widths of the command and result words
  localparam int unsigned ItemW   = 32;
  localparam int unsigned PrioW   = 16;
  localparam int unsigned StatusW = 2;

  // Command codes
  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRemove = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  // Per-cycle operation broadcast to every cell
  typedef struct packed {
    logic ins;  // insert, queue known not full
    logic rem;  // remove, queue known not empty
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Sorted minimum-priority queue built as a row of QUEUE_DEPTH compare/shift cells.
//
// Command channel: a word is taken at a rising edge with start_i high and busy_o
// low. mode_i selects insert or remove; item_in_i / prio_in_i carry the entry
// on insert and are ignored on remove. busy_o is always low: every command
// finishes in the cycle it is taken, so one command per cycle is sustained.
//
// Result channel: exactly one result word per command, shown for one cycle with
// done_o high, in the cycle after the command edge. The result comes
// from an output register; the receiver cannot stall and must take it then.
//
// Each cell compares the incoming priority with its own in parallel; the cells
// at or past the insert point shift one place toward the tail, a remove shifts
// the whole row toward the head. Equal priorities keep arrival order.
// Insert into a full queue and remove from an empty one leave the queue as is
// and report StFull / StEmpty. item_out_o / prio_out_o are zero unless the
// word is a successful remove. now_empty_o is the state after the command.
//
// Reset clears every cell's valid flag (queue empty) and the result strobe.
// No clearing pass: stored item and priority bits are only read when valid.
module sorted_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ITEM_BITS   = 32,
  parameter int unsigned PRIO_BITS   = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  input  wire                              mode_i,
  input  wire  [spq_pkg::ItemW-1:0]        item_in_i,
  input  wire  [spq_pkg::PrioW-1:0]        prio_in_i,
  output logic                             done_o,
  output logic [spq_pkg::ItemW-1:0]        item_out_o,
  output logic [spq_pkg::PrioW-1:0]        prio_out_o,
  output logic [spq_pkg::StatusW-1:0]      status_o,
  output logic                             now_empty_o
);
  import spq_pkg::*;

  typedef logic [ITEM_BITS-1:0] item_t;
  typedef logic [PRIO_BITS-1:0] prio_t;

  // Cell row taps
  logic  [QUEUE_DEPTH-1:0] go_w;
  logic  [QUEUE_DEPTH-1:0] valid_w;
  item_t                   item_w [QUEUE_DEPTH];
  prio_t                   prio_w [QUEUE_DEPTH];

  item_t     new_item;
  prio_t     new_prio;
  logic      accept;
  logic      full, empty;
  cell_cmd_t cmd;

  // Result word registers
  logic                done_q;
  logic [ItemW-1:0]    item_out_q, item_out_d;
  logic [PrioW-1:0]    prio_out_q, prio_out_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic                now_empty_q, now_empty_d;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign new_item = item_t'(item_in_i);
  assign new_prio = prio_t'(prio_in_i);

  // Valid flags fill from the head, so head/tail flags give empty/full
  assign empty = !valid_w[0];
  assign full  = valid_w[QUEUE_DEPTH-1];

  assign cmd.ins = accept && (mode_i == ModeInsert) && !full;
  assign cmd.rem = accept && (mode_i == ModeRemove) && !empty;

  for (genvar c = 0; c < QUEUE_DEPTH; c++) begin : g_cell
    logic  left_go, left_valid, right_valid;
    item_t left_item, right_item;
    prio_t left_prio, right_prio;

    if (c == 0) begin : g_head
      assign left_go    = 1'b0;
      assign left_valid = 1'b0;
      assign left_item  = new_item;
      assign left_prio  = new_prio;
    end else begin : g_mid_l
      assign left_go    = go_w[c-1];
      assign left_valid = valid_w[c-1];
      assign left_item  = item_w[c-1];
      assign left_prio  = prio_w[c-1];
    end

    if (c == QUEUE_DEPTH - 1) begin : g_tail
      assign right_valid = 1'b0;
      assign right_item  = item_w[c];
      assign right_prio  = prio_w[c];
    end else begin : g_mid_r
      assign right_valid = valid_w[c+1];
      assign right_item  = item_w[c+1];
      assign right_prio  = prio_w[c+1];
    end

    spq_cell #(
      .ITEM_BITS (ITEM_BITS),
      .PRIO_BITS (PRIO_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .new_item_i    (new_item),
      .new_prio_i    (new_prio),
      .left_go_i     (left_go),
      .left_valid_i  (left_valid),
      .left_item_i   (left_item),
      .left_prio_i   (left_prio),
      .right_valid_i (right_valid),
      .right_item_i  (right_item),
      .right_prio_i  (right_prio),
      .go_o          (go_w[c]),
      .valid_o       (valid_w[c]),
      .item_o        (item_w[c]),
      .prio_o        (prio_w[c])
    );
  end

  // Result word for the command taken this cycle
  always_comb begin
    item_out_d  = '0;
    prio_out_d  = '0;
    status_d    = StOk;
    now_empty_d = 1'b0;
    if (mode_i == ModeInsert) begin
      if (full) begin
        status_d = StFull;
      end
    end else begin
      if (empty) begin
        status_d    = StEmpty;
        now_empty_d = 1'b1;
      end else begin
        item_out_d  = ItemW'(item_w[0]);
        prio_out_d  = PrioW'(prio_w[0]);
        now_empty_d = !valid_w[1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_out_q  <= item_out_d;
      prio_out_q  <= prio_out_d;
      status_q    <= status_d;
      now_empty_q <= now_empty_d;
    end
  end

  assign done_o      = done_q;
  assign item_out_o  = item_out_q;
  assign prio_out_o  = prio_out_q;
  assign status_o    = status_q;
  assign now_empty_o = now_empty_q;

  // Valid flags stay packed toward the head
  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (((valid_w >> 1) & ~valid_w) == '0))
    else $error("valid flags not contiguous from head");

  // Head pair stays in priority order
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_w[1] |-> (prio_w[0] <= prio_w[1]))
    else $error("head entries out of order");

  // A taken insert into a non-full queue leaves it non-empty
  a_insert_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (valid_w[0] && done_o && status_o == StOk && !now_empty_o))
    else $error("insert did not land");

  // Empty-queue report agrees with the cell row
  a_empty_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && now_empty_o) |-> !valid_w[0])
    else $error("now_empty disagrees with queue contents");

  // Refused insert leaves the row full
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_i == ModeInsert && full) |=> (full && status_o == StFull))
    else $error("refused insert changed the queue");

endmodule

`default_nettype wire

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int unsigned ITEM_BITS = 32,
  parameter int unsigned PRIO_BITS = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  spq_pkg::cell_cmd_t    cmd_i,
  // new entry, broadcast
  input  wire [ITEM_BITS-1:0]   new_item_i,
  input  wire [PRIO_BITS-1:0]   new_prio_i,
  // left neighbor (toward head)
  input  wire                   left_go_i,
  input  wire                   left_valid_i,
  input  wire [ITEM_BITS-1:0]   left_item_i,
  input  wire [PRIO_BITS-1:0]   left_prio_i,
  // right neighbor (toward tail)
  input  wire                   right_valid_i,
  input  wire [ITEM_BITS-1:0]   right_item_i,
  input  wire [PRIO_BITS-1:0]   right_prio_i,
  // this cell's contents
  output logic                  go_o,
  output logic                  valid_o,
  output logic [ITEM_BITS-1:0]  item_o,
  output logic [PRIO_BITS-1:0]  prio_o
);
  import spq_pkg::*;

  logic                 valid_q, valid_d;
  logic [ITEM_BITS-1:0] item_q, item_d;
  logic [PRIO_BITS-1:0] prio_q, prio_d;

  // New entry belongs at or before this cell: strict compare keeps FIFO order on ties
  assign go_o = !valid_q || (new_prio_i < prio_q);

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    prio_d  = prio_q;
    if (cmd_i.ins && go_o) begin
      if (left_go_i) begin
        valid_d = left_valid_i;
        item_d  = left_item_i;
        prio_d  = left_prio_i;
      end else begin
        valid_d = 1'b1;
        item_d  = new_item_i;
        prio_d  = new_prio_i;
      end
    end else if (cmd_i.rem) begin
      valid_d = right_valid_i;
      item_d  = right_item_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign prio_o  = prio_q;

endmodule

`default_nettype wire
